FILE: rtl/est_pkg.sv
package est_pkg;

  localparam int unsigned FUNC_BITS   = 2;
  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned POS_BITS    = 10;

  // Operation codes of an input transaction
  localparam logic [FUNC_BITS-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_SEARCH = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISSING  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_APPENDED = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [FUNC_BITS-1:0]       func;
    logic signed [KEY_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [POS_BITS-1:0]    position;
  } out_item_t;

endpackage

FILE: rtl/exponential_search_table.sv
// Exponential-search table. The block holds an ascending table of signed
// words in a single-port-write, registered-read RAM. An append transaction
// stores its word at the end (or reports the table full), a clear
// transaction empties the table, and a search transaction looks its key up
// by exponential search: entry 0 first, then a probe index that doubles from
// 1 while the entry there is below the key, then a binary search over the
// bracket found. Issue a transaction by raising start while busy is low.
// Append, clear and unused codes finish in the accepting cycle; a search
// holds busy high while it walks the table, one RAM probe per cycle
// through the read port. Every transaction yields exactly one result,
// shown on out_result for one cycle with out_valid high, in the cycle
// after it completes. The receiver cannot stall: sample out_result
// whenever out_valid is high. Table contents are not cleared after reset;
// only entries below the current count are ever used in a compare.
module exponential_search_table
  import est_pkg::*;
#(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_result
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_GAL,
    S_BIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [WORD_BITS-1:0] key_r, key_nxt;
  logic [CW-1:0]        low_r, low_nxt;
  logic [CW-1:0]        high_r, high_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hip1_r, hip1_nxt;
  logic [CW-1:0]        mid_r, mid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_result_r, out_result_nxt;

  logic                 wr_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] in_word;
  logic signed [63:0]   in_ext;

  logic                 key_eq;
  logic                 key_lt;

  logic [CW:0]          sum_lo;
  logic [CW:0]          sum_hi;
  logic [CW:0]          sum_gal;
  logic [CW:0]          sum_top;
  logic [CW:0]          high2;
  logic [CW-1:0]        mid_p1;
  logic [CW-1:0]        high_p1;

  // Map a table index onto the fixed-width position field
  function automatic logic [POS_BITS-1:0] to_pos(input logic [CW-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[POS_BITS-1:0];
  endfunction

  // Take the low WORD_BITS bits of the key as a two's complement word
  assign in_ext  = 64'(in_item.value);
  assign in_word = in_ext[WORD_BITS-1:0];

  est_ram #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_word),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared compare of the key against the probed entry
  assign key_eq = (key_r == rd_data);
  assign key_lt = ($signed(key_r) < $signed(rd_data));

  // Candidate next probes, built alongside the compare and picked after it
  assign sum_lo  = {1'b0, lo_r} + {1'b0, mid_r} - (CW + 1)'(1);
  assign sum_hi  = {1'b0, mid_r} + {1'b0, hip1_r};
  assign sum_gal = {1'b0, low_r} + {1'b0, high_r};
  assign sum_top = {1'b0, high_r} + {1'b0, count_r} - (CW + 1)'(1);
  assign high2   = {high_r, 1'b0};
  assign mid_p1  = mid_r + ONE_C;
  assign high_p1 = high_r + ONE_C;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    lo_nxt         = lo_r;
    hip1_nxt       = hip1_r;
    mid_nxt        = mid_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    wr_en          = 1'b0;
    rd_addr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt                 = in_word;
          out_result_nxt.position = '0;
          unique case (in_item.func)
            FUNC_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r >= DEPTH_C) begin
                out_result_nxt.status = ST_FULL;
              end else begin
                wr_en                   = 1'b1;
                count_nxt               = count_r + ONE_C;
                out_result_nxt.status   = ST_APPENDED;
                out_result_nxt.position = to_pos(count_r);
              end
            end
            FUNC_SEARCH: begin
              if (count_r == '0) begin
                out_valid_nxt         = 1'b1;
                out_result_nxt.status = ST_MISSING;
              end else begin
                // Probe entry 0
                rd_addr   = '0;
                state_nxt = S_FIRST;
              end
            end
            FUNC_CLEAR: begin
              count_nxt             = '0;
              out_valid_nxt         = 1'b1;
              out_result_nxt.status = ST_CLEARED;
            end
            default: begin
              out_valid_nxt         = 1'b1;
              out_result_nxt.status = ST_MISSING;
            end
          endcase
        end
      end

      S_FIRST: begin
        if (key_eq) begin
          out_valid_nxt           = 1'b1;
          out_result_nxt.status   = ST_FOUND;
          out_result_nxt.position = '0;
          state_nxt               = S_IDLE;
        end else if (count_r == ONE_C) begin
          // Single entry: narrow over entry 0 alone
          lo_nxt    = '0;
          hip1_nxt  = ONE_C;
          mid_nxt   = '0;
          rd_addr   = '0;
          state_nxt = S_BIN;
        end else begin
          low_nxt   = '0;
          high_nxt  = ONE_C;
          rd_addr   = ONE_C[AW-1:0];
          state_nxt = S_GAL;
        end
      end

      S_GAL: begin
        if (key_eq) begin
          out_valid_nxt           = 1'b1;
          out_result_nxt.status   = ST_FOUND;
          out_result_nxt.position = to_pos(high_r);
          state_nxt               = S_IDLE;
        end else if (key_lt) begin
          // Entry high is above the key: narrow over low..high
          lo_nxt    = low_r;
          hip1_nxt  = high_p1;
          mid_nxt   = sum_gal[CW:1];
          rd_addr   = sum_gal[AW:1];
          state_nxt = S_BIN;
        end else if (high2 >= {1'b0, count_r}) begin
          // Doubling runs past the count: narrow over high..count-1
          lo_nxt    = high_r;
          hip1_nxt  = count_r;
          mid_nxt   = sum_top[CW:1];
          rd_addr   = sum_top[AW:1];
          state_nxt = S_BIN;
        end else begin
          // Advance the bracket and double the probe index
          low_nxt  = high_r;
          high_nxt = high2[CW-1:0];
          rd_addr  = high2[AW-1:0];
        end
      end

      S_BIN: begin
        if (key_eq) begin
          out_valid_nxt           = 1'b1;
          out_result_nxt.status   = ST_FOUND;
          out_result_nxt.position = to_pos(mid_r);
          state_nxt               = S_IDLE;
        end else if (key_lt) begin
          hip1_nxt = mid_r;
          if (lo_r < mid_r) begin
            mid_nxt = sum_lo[CW:1];
            rd_addr = sum_lo[AW:1];
          end else begin
            out_valid_nxt           = 1'b1;
            out_result_nxt.status   = ST_MISSING;
            out_result_nxt.position = '0;
            state_nxt               = S_IDLE;
          end
        end else begin
          lo_nxt = mid_p1;
          if (mid_p1 < hip1_r) begin
            mid_nxt = sum_hi[CW:1];
            rd_addr = sum_hi[AW:1];
          end else begin
            out_valid_nxt           = 1'b1;
            out_result_nxt.status   = ST_MISSING;
            out_result_nxt.position = '0;
            state_nxt               = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      key_r        <= key_nxt;
      low_r        <= low_nxt;
      high_r       <= high_nxt;
      lo_r         <= lo_nxt;
      hip1_r       <= hip1_nxt;
      mid_r        <= mid_nxt;
      out_valid_r  <= out_valid_nxt;
      out_result_r <= out_result_nxt;
    end
  end

  // Hold off new transactions while a search walks the table
  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

FILE: rtl/est_ram.sv
module est_ram
  import est_pkg::*;
#(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [WORD_BITS-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [WORD_BITS-1:0]         rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
